// ===== hdl/cpc_pkg.sv =====
// Shared types, widths and constants for the circle pair contact pipeline.
`default_nettype none
package cpc_pkg;

    localparam int COORD_FRAC_BITS  = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int SCALE_FRAC_BITS  = 12;

    localparam int IN_W    = 28;                    // position and offset fields
    localparam int CTR_W   = IN_W + 1;              // circle centre
    localparam int DIFF_W  = CTR_W + 1;             // centre difference
    localparam int MAG_W   = CTR_W;                 // magnitude of the difference
    localparam int RAD_W   = 27;
    localparam int SCL_W   = 16;
    localparam int RPROD_W = RAD_W + SCL_W;
    localparam int SUM_W   = RAD_W + 1;
    localparam int DSQ_W   = 2 * (MAG_W + 1) - 0;  // squared distance, even width
    localparam int DIST_W  = DSQ_W / 2;
    localparam int SQ_REM_W = DIST_W + 2;
    localparam int QUO_W   = NORMAL_FRAC_BITS + 1;
    localparam int NUM_W   = MAG_W + NORMAL_FRAC_BITS + 1;
    localparam int CPROD_W = QUO_W + RAD_W;
    localparam int OFF_W   = CPROD_W - NORMAL_FRAC_BITS;
    localparam int DEPTH_W = 30;
    localparam int NRM_W   = 16;
    localparam int CON_W   = 32;

    localparam logic [RPROD_W-SCALE_FRAC_BITS-1:0] RADIUS_MAX =
        (RPROD_W-SCALE_FRAC_BITS)'((64'd1 << RAD_W) - 64'd1);
    localparam logic [QUO_W-1:0] NORMAL_ONE = QUO_W'(1) << NORMAL_FRAC_BITS;

    typedef struct packed {
        logic signed [IN_W-1:0]  a_pos_x;
        logic signed [IN_W-1:0]  a_pos_y;
        logic signed [IN_W-1:0]  a_off_x;
        logic signed [IN_W-1:0]  a_off_y;
        logic        [RAD_W-1:0] a_radius;
        logic        [SCL_W-1:0] a_scale;
        logic signed [IN_W-1:0]  b_pos_x;
        logic signed [IN_W-1:0]  b_pos_y;
        logic signed [IN_W-1:0]  b_off_x;
        logic signed [IN_W-1:0]  b_off_y;
        logic        [RAD_W-1:0] b_radius;
        logic        [SCL_W-1:0] b_scale;
    } cpc_in_t;

    typedef struct packed {
        logic                    colliding;
        logic        [DEPTH_W-1:0] depth;
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic signed [CON_W-1:0] contact_x;
        logic signed [CON_W-1:0] contact_y;
        logic                    contact_count;
    } cpc_out_t;

    // Per-word data that rides alongside the square root and divider cells.
    typedef struct packed {
        logic                    hit;
        logic                    zero;
        logic                    sx;
        logic                    sy;
        logic        [MAG_W-1:0] mag_x;
        logic        [MAG_W-1:0] mag_y;
        logic        [RAD_W-1:0] ra;
        logic        [SUM_W-1:0] rsum;
        logic signed [CTR_W-1:0] acx;
        logic signed [CTR_W-1:0] acy;
    } cpc_side_t;

    typedef struct packed {
        logic [SQ_REM_W-1:0] rem;
        logic [DIST_W-1:0]   root;
        logic [DSQ_W-1:0]    x;
    } cpc_sqrt_t;

    typedef struct packed {
        logic [DIST_W-1:0] rem_x;
        logic [DIST_W-1:0] rem_y;
        logic [QUO_W-1:0]  num_x;
        logic [QUO_W-1:0]  num_y;
        logic [QUO_W-1:0]  q_x;
        logic [QUO_W-1:0]  q_y;
    } cpc_div_t;

endpackage
`default_nettype wire

// ===== hdl/cpc_sqrt_cell.sv =====
// One square root cell: settles one bit of the root per word.
`default_nettype none
module cpc_sqrt_cell
    import cpc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      en,
    input  wire logic      in_valid,
    input  wire cpc_side_t in_side,
    input  wire cpc_sqrt_t in_sq,
    output logic           out_valid,
    output cpc_side_t      out_side,
    output cpc_sqrt_t      out_sq
);

    logic                valid_reg;
    cpc_side_t           side_reg;
    cpc_sqrt_t           sq_reg;
    cpc_sqrt_t           sq_next;
    logic [SQ_REM_W+1:0] rem_w;
    logic [SQ_REM_W+1:0] trial;

    always_comb begin
        rem_w = {in_sq.rem, in_sq.x[DSQ_W-1 -: 2]};
        trial = {2'b00, in_sq.root, 2'b01};
        sq_next.x = {in_sq.x[DSQ_W-3:0], 2'b00};
        if (rem_w >= trial) begin
            sq_next.rem  = SQ_REM_W'(rem_w - trial);
            sq_next.root = {in_sq.root[DIST_W-2:0], 1'b1};
        end else begin
            sq_next.rem  = rem_w[SQ_REM_W-1:0];
            sq_next.root = {in_sq.root[DIST_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            side_reg <= in_side;
            sq_reg   <= sq_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_sq    = sq_reg;

endmodule
`default_nettype wire

// ===== hdl/cpc_div_cell.sv =====
// One divider cell: settles one quotient bit of both normal components.
`default_nettype none
module cpc_div_cell
    import cpc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire cpc_side_t         in_side,
    input  wire logic [DIST_W-1:0] in_dist,
    input  wire cpc_div_t          in_dv,
    output logic                   out_valid,
    output cpc_side_t              out_side,
    output logic [DIST_W-1:0]      out_dist,
    output cpc_div_t               out_dv
);

    logic              valid_reg;
    cpc_side_t         side_reg;
    logic [DIST_W-1:0] dist_reg;
    cpc_div_t          dv_reg;
    cpc_div_t          dv_next;
    logic [DIST_W:0]   rx_w;
    logic [DIST_W:0]   ry_w;
    logic [DIST_W:0]   dist_w;

    always_comb begin
        dist_w = {1'b0, in_dist};
        rx_w   = {in_dv.rem_x, in_dv.num_x[QUO_W-1]};
        ry_w   = {in_dv.rem_y, in_dv.num_y[QUO_W-1]};
        dv_next.num_x = {in_dv.num_x[QUO_W-2:0], 1'b0};
        dv_next.num_y = {in_dv.num_y[QUO_W-2:0], 1'b0};
        if (rx_w >= dist_w) begin
            dv_next.rem_x = DIST_W'(rx_w - dist_w);
            dv_next.q_x   = {in_dv.q_x[QUO_W-2:0], 1'b1};
        end else begin
            dv_next.rem_x = rx_w[DIST_W-1:0];
            dv_next.q_x   = {in_dv.q_x[QUO_W-2:0], 1'b0};
        end
        if (ry_w >= dist_w) begin
            dv_next.rem_y = DIST_W'(ry_w - dist_w);
            dv_next.q_y   = {in_dv.q_y[QUO_W-2:0], 1'b1};
        end else begin
            dv_next.rem_y = ry_w[DIST_W-1:0];
            dv_next.q_y   = {in_dv.q_y[QUO_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            side_reg <= in_side;
            dist_reg <= in_dist;
            dv_reg   <= dv_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_dist  = dist_reg;
    assign out_dv    = dv_reg;

endmodule
`default_nettype wire

// ===== hdl/circle_pair_contact.sv =====
// Top level of the pipelined circle-circle contact test.
// Usage:
//   Input words (two circles) arrive on s_valid/s_ready/s_data; one result
//   word per input leaves on m_valid/m_ready/m_data, in order.
//   The block is a straight pipeline: four front stages (centres and radius
//   products, differences, squares, compare), a row of 30 square root cells
//   (one root bit each), a setup stage, a row of 15 divider cells (one
//   normal bit each, both axes), a contact multiply stage and the output
//   register. Throughput is one word per cycle while the receiver does not
//   stall, set by the cell rows, which each take a new word in every cycle.
//   When the receiver stalls with a result held, the whole pipeline holds
//   and s_ready drops; s_ready is high whenever the output register is
//   empty or being taken.
//   Reset (aresetn low, synchronous) empties every stage; the block has no
//   other state and accepts a word in the first cycle after reset.
`default_nettype none
module circle_pair_contact
    import cpc_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire cpc_in_t s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output cpc_out_t     m_data
);

    localparam int SQRT_CELLS = DIST_W;
    localparam int DIV_CELLS  = QUO_W;

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // Stage 1: centres and raw radius products.
    logic                      v1_reg;
    logic signed [CTR_W-1:0]   acx1_reg, acy1_reg, bcx1_reg, bcy1_reg;
    logic        [RPROD_W-1:0] pa1_reg, pb1_reg;

    // Stage 2: saturated radii and centre differences.
    logic                    v2_reg;
    logic [RAD_W-1:0]        ra2_reg, rb2_reg;
    logic                    sx2_reg, sy2_reg;
    logic [MAG_W-1:0]        mx2_reg, my2_reg;
    logic signed [CTR_W-1:0] acx2_reg, acy2_reg;
    logic signed [DIFF_W-1:0] dx2, dy2;
    logic [RPROD_W-SCALE_FRAC_BITS-1:0] sa2, sb2;

    // Stage 3: squares.
    logic                    v3_reg;
    logic [2*MAG_W-1:0]      sqx3_reg, sqy3_reg;
    logic [2*SUM_W-1:0]      rsq3_reg;
    cpc_side_t               side3_reg;
    logic [SUM_W-1:0]        rsum2;

    // Stage 4: squared distance and hit test.
    logic                    v4_reg;
    cpc_side_t               side4_reg;
    cpc_side_t               side4_next;
    logic [DSQ_W-1:0]        dsq4_reg;
    logic [DSQ_W-1:0]        dsq3;

    always_comb begin
        dx2 = DIFF_W'(bcx1_reg) - DIFF_W'(acx1_reg);
        dy2 = DIFF_W'(bcy1_reg) - DIFF_W'(acy1_reg);
        sa2 = pa1_reg[RPROD_W-1:SCALE_FRAC_BITS];
        sb2 = pb1_reg[RPROD_W-1:SCALE_FRAC_BITS];
        rsum2 = SUM_W'(ra2_reg) + SUM_W'(rb2_reg);
        dsq3 = DSQ_W'(sqx3_reg) + DSQ_W'(sqy3_reg);
        side4_next      = side3_reg;
        side4_next.hit  = dsq3 <= DSQ_W'(rsq3_reg);
        side4_next.zero = dsq3 == '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
        if (en) begin
            acx1_reg <= CTR_W'(s_data.a_pos_x) + CTR_W'(s_data.a_off_x);
            acy1_reg <= CTR_W'(s_data.a_pos_y) + CTR_W'(s_data.a_off_y);
            bcx1_reg <= CTR_W'(s_data.b_pos_x) + CTR_W'(s_data.b_off_x);
            bcy1_reg <= CTR_W'(s_data.b_pos_y) + CTR_W'(s_data.b_off_y);
            pa1_reg  <= RPROD_W'(s_data.a_radius) * RPROD_W'(s_data.a_scale);
            pb1_reg  <= RPROD_W'(s_data.b_radius) * RPROD_W'(s_data.b_scale);

            ra2_reg  <= (sa2 > RADIUS_MAX) ? RAD_W'(RADIUS_MAX) : RAD_W'(sa2);
            rb2_reg  <= (sb2 > RADIUS_MAX) ? RAD_W'(RADIUS_MAX) : RAD_W'(sb2);
            sx2_reg  <= dx2[DIFF_W-1];
            sy2_reg  <= dy2[DIFF_W-1];
            mx2_reg  <= MAG_W'(dx2[DIFF_W-1] ? -dx2 : dx2);
            my2_reg  <= MAG_W'(dy2[DIFF_W-1] ? -dy2 : dy2);
            acx2_reg <= acx1_reg;
            acy2_reg <= acy1_reg;

            sqx3_reg <= (2*MAG_W)'(mx2_reg) * (2*MAG_W)'(mx2_reg);
            sqy3_reg <= (2*MAG_W)'(my2_reg) * (2*MAG_W)'(my2_reg);
            rsq3_reg <= (2*SUM_W)'(rsum2) * (2*SUM_W)'(rsum2);
            side3_reg.hit   <= 1'b0;
            side3_reg.zero  <= 1'b0;
            side3_reg.sx    <= sx2_reg;
            side3_reg.sy    <= sy2_reg;
            side3_reg.mag_x <= mx2_reg;
            side3_reg.mag_y <= my2_reg;
            side3_reg.ra    <= ra2_reg;
            side3_reg.rsum  <= rsum2;
            side3_reg.acx   <= acx2_reg;
            side3_reg.acy   <= acy2_reg;

            side4_reg      <= side4_next;
            dsq4_reg       <= dsq3;
        end
    end

    // Square root row.
    logic      sq_v    [SQRT_CELLS+1];
    cpc_side_t sq_side [SQRT_CELLS+1];
    cpc_sqrt_t sq_data [SQRT_CELLS+1];

    assign sq_v[0]         = v4_reg;
    assign sq_side[0]      = side4_reg;
    assign sq_data[0].rem  = '0;
    assign sq_data[0].root = '0;
    assign sq_data[0].x    = dsq4_reg;

    for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
        cpc_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (sq_v[i]),
            .in_side   (sq_side[i]),
            .in_sq     (sq_data[i]),
            .out_valid (sq_v[i+1]),
            .out_side  (sq_side[i+1]),
            .out_sq    (sq_data[i+1])
        );
    end

    // Setup of the rounded dividends for the normal.
    logic              v5_reg;
    cpc_side_t         side5_reg;
    logic [DIST_W-1:0] dist5_reg;
    cpc_div_t          dv5_reg;
    logic [NUM_W-1:0]  nx5, ny5;
    logic [DIST_W-1:0] dist4;

    always_comb begin
        dist4 = sq_data[SQRT_CELLS].root;
        nx5 = NUM_W'({sq_side[SQRT_CELLS].mag_x, {NORMAL_FRAC_BITS{1'b0}}})
              + NUM_W'(dist4 >> 1);
        ny5 = NUM_W'({sq_side[SQRT_CELLS].mag_y, {NORMAL_FRAC_BITS{1'b0}}})
              + NUM_W'(dist4 >> 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= sq_v[SQRT_CELLS];
        end
        if (en) begin
            side5_reg     <= sq_side[SQRT_CELLS];
            dist5_reg     <= dist4;
            dv5_reg.rem_x <= DIST_W'(nx5[NUM_W-1:QUO_W]);
            dv5_reg.rem_y <= DIST_W'(ny5[NUM_W-1:QUO_W]);
            dv5_reg.num_x <= nx5[QUO_W-1:0];
            dv5_reg.num_y <= ny5[QUO_W-1:0];
            dv5_reg.q_x   <= '0;
            dv5_reg.q_y   <= '0;
        end
    end

    // Divider row.
    logic              dv_v    [DIV_CELLS+1];
    cpc_side_t         dv_side [DIV_CELLS+1];
    logic [DIST_W-1:0] dv_dist [DIV_CELLS+1];
    cpc_div_t          dv_data [DIV_CELLS+1];

    assign dv_v[0]    = v5_reg;
    assign dv_side[0] = side5_reg;
    assign dv_dist[0] = dist5_reg;
    assign dv_data[0] = dv5_reg;

    for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
        cpc_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (dv_v[j]),
            .in_side   (dv_side[j]),
            .in_dist   (dv_dist[j]),
            .in_dv     (dv_data[j]),
            .out_valid (dv_v[j+1]),
            .out_side  (dv_side[j+1]),
            .out_dist  (dv_dist[j+1]),
            .out_dv    (dv_data[j+1])
        );
    end

    // Contact multiply stage.
    logic               v6_reg;
    cpc_side_t          side6_reg;
    logic [DIST_W-1:0]  dist6_reg;
    logic [QUO_W-1:0]   qx6_reg, qy6_reg;
    logic [CPROD_W-1:0] px6_reg, py6_reg;
    logic [QUO_W-1:0]   qx5, qy5;

    always_comb begin
        qx5 = dv_data[DIV_CELLS].q_x;
        qy5 = dv_data[DIV_CELLS].q_y;
        if (qx5 > NORMAL_ONE) begin
            qx5 = NORMAL_ONE;
        end
        if (qy5 > NORMAL_ONE) begin
            qy5 = NORMAL_ONE;
        end
        // Coincident centres use the fixed normal along +x.
        if (dv_side[DIV_CELLS].zero) begin
            qx5 = NORMAL_ONE;
            qy5 = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= dv_v[DIV_CELLS];
        end
        if (en) begin
            side6_reg <= dv_side[DIV_CELLS];
            dist6_reg <= dv_dist[DIV_CELLS];
            qx6_reg   <= qx5;
            qy6_reg   <= qy5;
            px6_reg   <= CPROD_W'(qx5) * CPROD_W'(dv_side[DIV_CELLS].ra);
            py6_reg   <= CPROD_W'(qy5) * CPROD_W'(dv_side[DIV_CELLS].ra);
        end
    end

    // Output register.
    logic         out_valid_reg;
    cpc_out_t     out_reg;
    cpc_out_t     out_next;
    logic [CPROD_W-1:0] rx7, ry7;
    logic [OFF_W-1:0]   ox7, oy7;
    logic signed [CON_W-1:0] cax7, cay7;

    always_comb begin
        rx7  = px6_reg + (CPROD_W'(1) << (NORMAL_FRAC_BITS - 1));
        ry7  = py6_reg + (CPROD_W'(1) << (NORMAL_FRAC_BITS - 1));
        ox7  = rx7[CPROD_W-1:NORMAL_FRAC_BITS];
        oy7  = ry7[CPROD_W-1:NORMAL_FRAC_BITS];
        cax7 = CON_W'(side6_reg.acx);
        cay7 = CON_W'(side6_reg.acy);
        out_next = '0;
        if (side6_reg.hit) begin
            out_next.colliding     = 1'b1;
            out_next.contact_count = 1'b1;
            out_next.normal_x = side6_reg.sx ? -NRM_W'(qx6_reg) : NRM_W'(qx6_reg);
            out_next.normal_y = side6_reg.sy ? -NRM_W'(qy6_reg) : NRM_W'(qy6_reg);
            if (side6_reg.zero) begin
                out_next.depth     = DEPTH_W'(side6_reg.ra);
                out_next.contact_x = cax7;
                out_next.contact_y = cay7;
            end else begin
                out_next.depth = DEPTH_W'(side6_reg.rsum) - DEPTH_W'(dist6_reg);
                out_next.contact_x = side6_reg.sx ? cax7 - CON_W'(ox7) : cax7 + CON_W'(ox7);
                out_next.contact_y = side6_reg.sy ? cay7 - CON_W'(oy7) : cay7 + CON_W'(oy7);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= v6_reg;
        end
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef ASSERT_OFF
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.contact_count == m_data.colliding)
        else $error("contact count differs from collision flag");

    a_apart_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.colliding |-> m_data.depth == '0
            && m_data.normal_x == '0 && m_data.normal_y == '0)
        else $error("apart result carries nonzero fields");

    a_normal_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.colliding |->
            (m_data.normal_x <= 16'sd16384 && m_data.normal_x >= -16'sd16384))
        else $error("normal x out of unit range");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |=> $stable(v6_reg) && $stable(v5_reg))
        else $error("pipeline moved while stalled");
`endif

endmodule
`default_nettype wire
